// ===== hdl/capm_pkg.sv =====
// shared types, constants and helpers for the attitude controller
package capm_pkg;

    localparam int GainFracBits = 12;
    localparam int SumWidth     = 24;
    localparam int ProdWidth    = 42;

    localparam logic signed [17:0] WrapLimit   = 18'sd21120;
    localparam logic signed [17:0] FullTurn    = 18'sd23040;
    localparam logic signed [17:0] JumpLimit   = 18'sd640;
    localparam logic signed [15:0] StickCentre = 16'sd1500;
    localparam logic signed [15:0] ThrSpan     = 16'sd3000;
    localparam logic signed [15:0] StopThr     = 16'sd300;
    localparam logic signed [SumWidth+1:0] DutyMin = 500;
    localparam logic signed [SumWidth+1:0] DutyMax = 1000;

    // ceil(2^24 / 25): |stick| * 32 / 25 is (|stick| * StickRecip) >> 19
    localparam logic [19:0] StickRecip = 20'd671089;

    // register indexes
    localparam logic [2:0] RegAngP  = 3'd0;
    localparam logic [2:0] RegAngD  = 3'd1;
    localparam logic [2:0] RegRateP = 3'd2;
    localparam logic [2:0] RegRateD = 3'd3;
    localparam logic [2:0] RegLvlP  = 3'd4;
    localparam logic [2:0] RegLvlR  = 3'd5;
    localparam logic [2:0] RegLvlY  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETPT, ST_ANG_P, ST_ANG_D, ST_RATE_P, ST_RATE_D, ST_MIX, ST_OUT
    } state_t;

    // multiply-accumulate unit command
    typedef struct packed {
        logic                        clear;
        logic                        en;
        logic [15:0]                 gain;
        logic signed [SumWidth:0]    operand;
    } mac_cmd_t;

    // saturate a wide value to SumWidth signed bits
    function automatic logic signed [SumWidth-1:0] sat_sum(input logic signed [ProdWidth-1:0] v);
        logic signed [ProdWidth-1:0] hi;
        logic signed [ProdWidth-1:0] lo;
        begin
            hi = ProdWidth'((64'sd1 <<< (SumWidth - 1)) - 64'sd1);
            lo = -hi - ProdWidth'(1);
            if (v > hi) sat_sum = hi[SumWidth-1:0];
            else if (v < lo) sat_sum = lo[SumWidth-1:0];
            else sat_sum = v[SumWidth-1:0];
        end
    endfunction

    // saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        begin
            if (v > 18'sd32767) sat16 = 16'sh7fff;
            else if (v < -18'sd32768) sat16 = 16'sh8000;
            else sat16 = v[15:0];
        end
    endfunction

endpackage

// ===== hdl/cascaded_attitude_pd_mixer.sv =====
// top level: register file, sequencer and mixer of the attitude controller
// one request at a time; a new request is taken only once the result has been taken
// each request is worked through the single MAC, one axis after another
// the MAC does one gain product per cycle: angle P, angle D, rate P, rate D per axis
// reset (aresetn low, synchronous): gains to defaults; levels, setpoints, previous errors and held sticks zero
module cascaded_attitude_pd_mixer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // meas_pitch, meas_roll, meas_yaw, rate_pitch, rate_roll, rate_yaw,
    // packet_valid, throttle_raw, fore_aft_raw, side_raw, stop_request
    input  logic [143:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_front, duty_back, duty_left, duty_right
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import capm_pkg::*;

    localparam int SW = SumWidth;

    logic [15:0] kap_reg, kad_reg, krp_reg, krd_reg;
    logic signed [15:0] lvl_reg [3];
    logic signed [15:0] thr_reg, fa_reg, side_reg;
    logic stop_reg;
    logic signed [15:0] sp_reg [3];
    logic signed [16:0] aprev_reg [3];
    logic signed [SW-1:0] rprev_reg [3];
    logic signed [15:0] meas_reg [3], rate_reg [3];
    logic signed [SW-1:0] corr_reg [3];
    logic signed [SW-1:0] rerr_reg;
    logic [1:0] axis_reg, axis_next;
    state_t state_reg, state_next;
    logic [39:0] out_reg;
    logic out_valid_reg;

    logic wr;
    logic [2:0] widx;
    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign widx = paddr[4:2];

    // register read
    always_comb begin
        prdata = '0;
        unique case (widx)
            RegAngP:  prdata = {16'd0, kap_reg};
            RegAngD:  prdata = {16'd0, kad_reg};
            RegRateP: prdata = {16'd0, krp_reg};
            RegRateD: prdata = {16'd0, krd_reg};
            RegLvlP:  prdata = {{16{lvl_reg[0][15]}}, lvl_reg[0]};
            RegLvlR:  prdata = {{16{lvl_reg[1][15]}}, lvl_reg[1]};
            RegLvlY:  prdata = {{16{lvl_reg[2][15]}}, lvl_reg[2]};
            default:  prdata = '0;
        endcase
    end

    // shared mac
    mac_cmd_t cmd;
    logic signed [ProdWidth-1:0] acc;
    capm_mac u_mac (.aclk(aclk), .aresetn(aresetn), .cmd(cmd), .acc(acc));

    // current axis values
    logic signed [16:0] aerr;
    logic signed [SW-1:0] pd_out, rerr_c;
    logic signed [SW:0] rerr_w;
    assign aerr = 17'(sp_reg[axis_reg]) - 17'(meas_reg[axis_reg]);
    assign pd_out = sat_sum(acc >>> GainFracBits);
    assign rerr_w = (SW+1)'(pd_out) - (SW+1)'(rate_reg[axis_reg]);
    assign rerr_c = sat_sum(ProdWidth'(rerr_w));

    // mac command per state
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_ANG_P: begin
                cmd.en = 1'b1; cmd.clear = 1'b1; cmd.gain = kap_reg;
                cmd.operand = (SW+1)'(aerr);
            end
            ST_ANG_D: begin
                cmd.en = 1'b1; cmd.gain = kad_reg;
                cmd.operand = (SW+1)'(aerr) - (SW+1)'(aprev_reg[axis_reg]);
            end
            ST_RATE_P: begin
                cmd.en = 1'b1; cmd.clear = 1'b1; cmd.gain = krp_reg;
                cmd.operand = (SW+1)'(rerr_c);
            end
            ST_RATE_D: begin
                cmd.en = 1'b1; cmd.gain = krd_reg;
                cmd.operand = (SW+1)'(rerr_reg) - (SW+1)'(rprev_reg[axis_reg]);
            end
            default: cmd = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid && s_tready) state_next = ST_SETPT;
            ST_SETPT:  begin state_next = ST_ANG_P; axis_next = 2'd0; end
            ST_ANG_P:  state_next = ST_ANG_D;
            ST_ANG_D:  state_next = ST_RATE_P;
            ST_RATE_P: state_next = ST_RATE_D;
            ST_RATE_D: state_next = ST_MIX;
            ST_MIX: begin
                if (axis_reg == 2'd2) state_next = ST_OUT;
                else begin
                    state_next = ST_ANG_P;
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;

    // held throttle: (3000 - raw) / 2 truncated toward zero
    logic signed [16:0] thr_diff, thr_half;
    assign thr_diff = 17'(ThrSpan) - $signed({3'd0, s_tdata[110:97]});
    assign thr_half = (thr_diff + $signed({16'd0, thr_diff[16]})) >>> 1;

    // setpoint candidates from held sticks, stick*32/25 by reciprocal multiply
    logic signed [15:0] stick [2];
    logic signed [15:0] nsp [2];
    always_comb begin
        stick[0] = fa_reg;
        stick[1] = side_reg;
        for (int i = 0; i < 2; i++) begin
            logic [14:0] mag;
            logic [34:0] prod;
            logic signed [17:0] quo;
            logic signed [17:0] cand;
            logic signed [15:0] c16;
            logic signed [17:0] d;
            mag = stick[i][15] ? 15'(-stick[i]) : stick[i][14:0];
            prod = 35'(mag) * 35'(StickRecip);
            quo = $signed({2'b00, prod[34:19]});
            if (stick[i][15]) quo = -quo;
            cand = 18'(lvl_reg[i]) + quo;
            c16 = sat16(cand);
            d = 18'(c16) - 18'(sp_reg[i]);
            nsp[i] = (d > JumpLimit || d < -JumpLimit) ? sp_reg[i] : c16;
        end
    end

    logic signed [17:0] yd;
    assign yd = 18'(sp_reg[2]) - 18'(meas_reg[2]);

    // mixer sums
    logic signed [SW+1:0] thr_w, mix [4];
    logic [9:0] duty [4];
    always_comb begin
        thr_w = (SW+2)'(stop_reg ? StopThr : thr_reg);
        mix[0] = thr_w - (SW+2)'(corr_reg[0]) - (SW+2)'(corr_reg[2]);
        mix[1] = thr_w + (SW+2)'(corr_reg[0]) - (SW+2)'(corr_reg[2]);
        mix[2] = thr_w - (SW+2)'(corr_reg[1]) + (SW+2)'(corr_reg[2]);
        mix[3] = thr_w + (SW+2)'(corr_reg[1]) + (SW+2)'(corr_reg[2]);
        if (stop_reg) for (int i = 0; i < 4; i++) mix[i] = thr_w;
        for (int i = 0; i < 4; i++) begin
            if (mix[i] > DutyMax) duty[i] = 10'(DutyMax);
            else if (mix[i] < DutyMin) duty[i] = 10'(DutyMin);
            else duty[i] = mix[i][9:0];
        end
    end

    // sequenced registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg <= '0;
            kap_reg <= 16'd10240; kad_reg <= '0; krp_reg <= 16'd2458; krd_reg <= 16'd41;
            thr_reg <= '0; fa_reg <= '0; side_reg <= '0; stop_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                lvl_reg[i] <= '0; sp_reg[i] <= '0;
                aprev_reg[i] <= '0; rprev_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            // configuration writes
            if (wr) begin
                unique case (widx)
                    RegAngP:  kap_reg <= pwdata[15:0];
                    RegAngD:  kad_reg <= pwdata[15:0];
                    RegRateP: krp_reg <= pwdata[15:0];
                    RegRateD: krd_reg <= pwdata[15:0];
                    RegLvlP:  begin lvl_reg[0] <= pwdata[15:0]; sp_reg[0] <= pwdata[15:0]; end
                    RegLvlR:  begin lvl_reg[1] <= pwdata[15:0]; sp_reg[1] <= pwdata[15:0]; end
                    RegLvlY:  begin lvl_reg[2] <= pwdata[15:0]; sp_reg[2] <= pwdata[15:0]; end
                    default:  ;
                endcase
            end
            // request capture and packet
            if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
                meas_reg[0] <= s_tdata[15:0];  meas_reg[1] <= s_tdata[31:16];
                meas_reg[2] <= s_tdata[47:32]; rate_reg[0] <= s_tdata[63:48];
                rate_reg[1] <= s_tdata[79:64]; rate_reg[2] <= s_tdata[95:80];
                if (s_tdata[96]) begin
                    thr_reg <= thr_half[15:0];
                    fa_reg <= $signed({2'd0, s_tdata[124:111]}) - StickCentre;
                    side_reg <= $signed({2'd0, s_tdata[138:125]}) - StickCentre;
                    stop_reg <= s_tdata[139];
                end
            end
            // setpoints and yaw wrap
            if (state_reg == ST_SETPT) begin
                sp_reg[0] <= nsp[0];
                sp_reg[1] <= nsp[1];
                if (yd > WrapLimit) sp_reg[2] <= sat16(18'(sp_reg[2]) - FullTurn);
                else if (yd < -WrapLimit) sp_reg[2] <= sat16(18'(sp_reg[2]) + FullTurn);
            end
            if (state_reg == ST_RATE_P) begin
                rerr_reg <= rerr_c;
                aprev_reg[axis_reg] <= aerr;
            end
            if (state_reg == ST_MIX) begin
                corr_reg[axis_reg] <= pd_out;
                rprev_reg[axis_reg] <= rerr_reg;
            end
            // result register
            if (state_reg == ST_OUT) begin
                out_reg <= {duty[3], duty[2], duty[1], duty[0]};
                out_valid_reg <= 1'b1;
            end else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_tvalid) else $error("result not raised");
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] >= 10'd500 && m_tdata[9:0] <= 10'd1000))
        else $error("duty out of range");
endmodule

// ===== hdl/capm_mac.sv =====
// shared signed-by-unsigned multiply-accumulate unit
module capm_mac (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  capm_pkg::mac_cmd_t                     cmd,
    output logic signed [capm_pkg::ProdWidth-1:0]  acc
);
    import capm_pkg::*;

    logic signed [ProdWidth-1:0] acc_reg, acc_next;
    logic signed [ProdWidth-1:0] prod;

    // one 17x25 product a cycle
    assign prod = ProdWidth'($signed({1'b0, cmd.gain})) * ProdWidth'(cmd.operand);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.en) acc_next = (cmd.clear ? '0 : acc_reg) + prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) acc_reg <= '0;
        else acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule
